FILE: hw/rtl/quoted_printable_encoder_defines.svh
// Assertion macros for the quoted-printable encoder.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef QUOTED_PRINTABLE_ENCODER_DEFINES_SVH
`define QUOTED_PRINTABLE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpe assertion failed");

`endif

FILE: hw/rtl/qpe_pkg.sv
`default_nettype none

package qpe_pkg;

    // Character codes used by the encoder.
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_DOT = 8'd46;
    localparam logic [7:0] CH_EQ  = 8'd61;
    localparam logic [7:0] CH_DEL = 8'd127;

    // Length of the LF "From " pattern; match indexes at or above it never match.
    localparam logic [2:0] FROM_LEN = 3'd6;

    // Longest byte sequence one request can produce.
    localparam int MAX_SEQ = 5;
    localparam int SEQ_W   = 8 * MAX_SEQ;

    // Reset value of the line length register.
    localparam logic [9:0] LINE_LENGTH_RESET = 10'd71;

    // Body of an encoded request.
    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_RAW,
        BODY_HEX
    } body_t;

    // One classified request passed from the front end to the back end.
    typedef struct packed {
        logic [7:0] data;
        logic       lead_brk;
        body_t      body;
        logic       trail_brk;
    } cmd_t;

    // Uppercase hex digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = 8'h30 + {4'h0, nib};
        end
        else
        begin
            ch = 8'h37 + {4'h0, nib};
        end
        return ch;
    endfunction

    // Character expected at each position of LF "From ".
    function automatic logic [7:0] from_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = CH_LF;
            3'd1:    ch = 8'h46;
            3'd2:    ch = 8'h72;
            3'd3:    ch = 8'h6F;
            3'd4:    ch = 8'h6D;
            3'd5:    ch = CH_SP;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/qpe_front.sv
`default_nettype none

module qpe_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [9:0]   cfg_wr_data,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   data_byte,
    input  wire logic         end_of_input,
    input  wire logic         fifo_full,
    output logic              cmd_push,
    output qpe_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        MARK_NONE,
        MARK_LF,
        MARK_DOT
    } mark_t;

    logic [9:0]  line_length_reg;
    logic [10:0] col_reg, col_next;
    logic        tw_reg, tw_next;
    mark_t       mark_reg, mark_next;
    logic [2:0]  fidx_reg, fidx_next;

    logic        accept;
    logic [10:0] col_p1;
    logic [10:0] col_p3;
    logic [10:0] ll_ext;
    logic        pattern_hit;
    logic        is_esc;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;
    assign col_p1   = col_reg + 11'd1;
    assign col_p3   = col_reg + 11'd3;
    assign ll_ext   = {1'b0, line_length_reg};

    // A byte continues the LF "From " match when it is the next pattern character.
    assign pattern_hit = (fidx_reg < qpe_pkg::FROM_LEN)
                      && (qpe_pkg::from_char(fidx_reg) == data_byte);

    // Bytes that must be written as an escape.
    assign is_esc = (data_byte < qpe_pkg::CH_SP) || (data_byte == qpe_pkg::CH_EQ)
                 || (data_byte >= qpe_pkg::CH_DEL);

    // Classify the byte into a request and update the line state.
    always_comb
    begin
        col_next  = col_reg;
        tw_next   = tw_reg;
        mark_next = mark_reg;
        fidx_next = fidx_reg;
        cmd.data      = data_byte;
        cmd.lead_brk  = 1'b0;
        cmd.body      = qpe_pkg::BODY_NONE;
        cmd.trail_brk = 1'b0;
        cmd_push      = 1'b0;
        if (accept)
        begin
            if (end_of_input)
            begin
                cmd.trail_brk = (col_reg != 11'd0);
                cmd_push      = (col_reg != 11'd0);
                col_next  = 11'd0;
                tw_next   = 1'b0;
                mark_next = MARK_NONE;
                fidx_next = 3'd1;
            end
            else if (data_byte == qpe_pkg::CH_TAB || data_byte == qpe_pkg::CH_SP)
            begin
                cmd_push  = 1'b1;
                fidx_next = 3'd0;
                if (pattern_hit)
                begin
                    // A space completing "From " at a line start is escaped.
                    cmd.body = qpe_pkg::BODY_HEX;
                    col_next = col_p3;
                end
                else
                begin
                    cmd.body = qpe_pkg::BODY_RAW;
                    tw_next  = 1'b1;
                    col_next = col_p1;
                    if (col_p1 > ll_ext)
                    begin
                        cmd.trail_brk = 1'b1;
                        tw_next   = 1'b0;
                        col_next  = 11'd0;
                        mark_next = MARK_LF;
                        fidx_next = 3'd1;
                    end
                end
            end
            else if (data_byte == qpe_pkg::CH_LF)
            begin
                // Protect trailing whitespace or a lone dot with a soft break.
                cmd_push     = 1'b1;
                cmd.body     = qpe_pkg::BODY_RAW;
                cmd.lead_brk = tw_reg || (mark_reg == MARK_DOT);
                tw_next   = 1'b0;
                col_next  = 11'd0;
                mark_next = MARK_LF;
                fidx_next = 3'd1;
            end
            else if (is_esc)
            begin
                cmd_push = 1'b1;
                cmd.body = qpe_pkg::BODY_HEX;
                tw_next  = 1'b0;
                if (col_p3 > ll_ext)
                begin
                    cmd.trail_brk = 1'b1;
                    col_next  = 11'd0;
                    mark_next = MARK_LF;
                    fidx_next = 3'd1;
                end
                else
                begin
                    col_next  = col_p3;
                    fidx_next = 3'd0;
                    mark_next = MARK_NONE;
                end
            end
            else
            begin
                cmd_push  = 1'b1;
                cmd.body  = qpe_pkg::BODY_RAW;
                tw_next   = 1'b0;
                fidx_next = pattern_hit ? (fidx_reg + 3'd1) : 3'd0;
                if (data_byte == qpe_pkg::CH_DOT && mark_reg == MARK_LF)
                begin
                    mark_next = MARK_DOT;
                end
                else
                begin
                    mark_next = MARK_NONE;
                end
                col_next = col_p1;
                if (col_p1 > ll_ext)
                begin
                    cmd.trail_brk = 1'b1;
                    col_next  = 11'd0;
                    mark_next = MARK_LF;
                    fidx_next = 3'd1;
                end
            end
        end
    end

    // Line state and the line length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= qpe_pkg::LINE_LENGTH_RESET;
            col_reg         <= 11'd0;
            tw_reg          <= 1'b0;
            mark_reg        <= MARK_NONE;
            fidx_reg        <= 3'd1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                line_length_reg <= cfg_wr_data;
            end
            col_reg  <= col_next;
            tw_reg   <= tw_next;
            mark_reg <= mark_next;
            fidx_reg <= fidx_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/qpe_cmd_fifo.sv
`default_nettype none

module qpe_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire qpe_pkg::cmd_t  push_data,
    input  wire logic           pop,
    output qpe_pkg::cmd_t       head,
    output logic                full,
    output logic                empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qpe_pkg::cmd_t entry_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries hold payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/qpe_back.sv
`default_nettype none

module qpe_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fifo_empty,
    input  wire qpe_pkg::cmd_t  fifo_head,
    output logic                fifo_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                last_of_run
);

    logic [qpe_pkg::SEQ_W-1:0] seq_reg, seq_next;
    logic [2:0]                len_reg, len_next;

    logic [qpe_pkg::SEQ_W-1:0] seq_build;
    logic [qpe_pkg::SEQ_W-1:0] seq_load;
    logic [2:0]                len_load;
    logic [5:0]                shamt;
    logic                      advance;
    logic                      load;

    assign out_valid   = (len_reg != 3'd0);
    assign out_byte    = seq_reg[qpe_pkg::SEQ_W-1 -: 8];
    assign last_of_run = (len_reg == 3'd1);
    assign advance     = out_valid && out_ready;
    assign load        = !fifo_empty && (!out_valid || (advance && last_of_run));
    assign fifo_pop    = load;

    // Expand the queued request into its byte sequence, first byte on top.
    always_comb
    begin
        seq_build = '0;
        len_load  = 3'd0;
        if (fifo_head.lead_brk)
        begin
            seq_build = {seq_build[qpe_pkg::SEQ_W-17:0], qpe_pkg::CH_EQ, qpe_pkg::CH_LF};
            len_load  = len_load + 3'd2;
        end
        case (fifo_head.body)
            qpe_pkg::BODY_RAW:
            begin
                seq_build = {seq_build[qpe_pkg::SEQ_W-9:0], fifo_head.data};
                len_load  = len_load + 3'd1;
            end
            qpe_pkg::BODY_HEX:
            begin
                seq_build = {seq_build[qpe_pkg::SEQ_W-25:0], qpe_pkg::CH_EQ,
                             qpe_pkg::hex_digit(fifo_head.data[7:4]),
                             qpe_pkg::hex_digit(fifo_head.data[3:0])};
                len_load  = len_load + 3'd3;
            end
            default:
            begin
                seq_build = seq_build;
            end
        endcase
        if (fifo_head.trail_brk)
        begin
            seq_build = {seq_build[qpe_pkg::SEQ_W-17:0], qpe_pkg::CH_EQ, qpe_pkg::CH_LF};
            len_load  = len_load + 3'd2;
        end
        shamt    = {(3'(qpe_pkg::MAX_SEQ) - len_load), 3'b000};
        seq_load = seq_build << shamt;
    end

    // Output shift register: load a new request or move to the next byte.
    always_comb
    begin
        seq_next = seq_reg;
        len_next = len_reg;
        if (load)
        begin
            seq_next = seq_load;
            len_next = len_load;
        end
        else if (advance)
        begin
            seq_next = {seq_reg[qpe_pkg::SEQ_W-9:0], 8'h00};
            len_next = len_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= 3'd0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/quoted_printable_encoder.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   data_byte, end_of_input
// output    out_valid / out_ready out_byte, last_of_run
// config    cfg_wr_en             cfg_wr_data (line length, 10 bits)
//
// The front end takes one input byte per cycle while the request queue has room.
// The back end sends one encoded byte per cycle while out_ready is high, so an item
// yields 1 byte (plain byte), 3 (escape, or a byte plus soft break) or up to 5 bytes;
// the single output byte port sets the sustained rate; first output is registered in
// the queue and the shift register. Reset clears line state, empties the queue and sets
// the line length to 71. Either side may stall; the queue decouples them.
`default_nettype none

`include "quoted_printable_encoder_defines.svh"

module quoted_printable_encoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [9:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last_of_run
);

    qpe_pkg::cmd_t cmd;
    qpe_pkg::cmd_t fifo_head;
    logic          cmd_push;
    logic          fifo_pop;
    logic          fifo_full;
    logic          fifo_empty;

    // Front end: classification and line state.
    qpe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .fifo_full    (fifo_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd)
    );

    // Request queue between the two halves.
    qpe_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .pop       (fifo_pop),
        .head      (fifo_head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // Back end: byte sequencing onto the output channel.
    qpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .fifo_head   (fifo_head),
        .fifo_pop    (fifo_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // A request is never pushed into a full queue.
    `QPE_ASSERT_IMPL(a_no_push_full, cmd_push, !fifo_full)
    // With a request waiting, the output stays busy after a run's last byte.
    `QPE_ASSERT_NEXT(a_back_to_back, out_valid && out_ready && last_of_run && !fifo_empty, out_valid)
    // Output only starts from a queued request.
    `QPE_ASSERT_IMPL(a_start_from_queue, $rose(out_valid), $past(!fifo_empty))

endmodule

`default_nettype wire
